// ===== rtl/crtp_pkg.sv =====
// ----------------------------------------------------------------------------
// Cartridge ROM transfer port package
// Shared codes, register bit positions, constants and item types.
// ----------------------------------------------------------------------------
`default_nettype none

package crtp_pkg;

  localparam int unsigned COMMAND_LENGTH = 8;
  localparam int unsigned CMD_IDX_W      = $clog2(COMMAND_LENGTH);

  localparam logic [3:0] CYCLES_PER_WORD = 4'd8;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] REG_CMD     = 2'd0;
  localparam logic [1:0] REG_CTRL    = 2'd1;
  localparam logic [1:0] REG_DATA    = 2'd2;
  localparam logic [1:0] REG_AUX     = 2'd3;

  localparam logic [1:0] CMD_DUMMY   = 2'd0;
  localparam logic [1:0] CMD_HEADER  = 2'd1;
  localparam logic [1:0] CMD_CHIP_ID = 2'd2;
  localparam logic [1:0] CMD_KEY1    = 2'd3;

  localparam logic [7:0] OPC_DUMMY   = 8'h9F;
  localparam logic [7:0] OPC_HEADER  = 8'h00;
  localparam logic [7:0] OPC_CHIP_ID = 8'h90;
  localparam logic [7:0] OPC_KEY1    = 8'h3C;

  localparam int unsigned BUSY_BIT   = 31;
  localparam int unsigned READY_BIT  = 23;
  localparam int unsigned IRQ_EN_BIT = 14;

  localparam logic [31:0] DUMMY_WORD   = 32'hFFFF_FFFF;
  localparam logic [31:0] CHIP_ID_WORD = 32'h0000_3FC2;
  localparam logic [14:0] BLOCK_BASE   = 15'h0100;
  localparam logic [14:0] BLOCK_SHORT  = 15'd4;
  localparam logic [14:0] WORD_BYTES   = 15'd4;
  localparam logic [11:0] HEADER_STEP  = 12'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  reg_select;
    logic [2:0]  byte_index;
    logic        word_read;
    logic [31:0] write_data;
    logic [7:0]  tick_cycles;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_pulse;
    logic        bad_command;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/crtp_if.sv =====
// ----------------------------------------------------------------------------
// Cartridge ROM transfer port channels
// Valid/ready channels for bus items in and results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface crtp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [1:0]  reg_select;
  logic [2:0]  byte_index;
  logic        word_read;
  logic [31:0] write_data;
  logic [7:0]  tick_cycles;

  modport source (
    output valid, operation, reg_select, byte_index, word_read, write_data, tick_cycles,
    input  ready
  );
  modport sink (
    input  valid, operation, reg_select, byte_index, word_read, write_data, tick_cycles,
    output ready
  );
endinterface

interface crtp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_pulse;
  logic        bad_command;

  modport source (
    output valid, read_data, irq_pulse, bad_command,
    input  ready
  );
  modport sink (
    input  valid, read_data, irq_pulse, bad_command,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/crtp_core.sv =====
// ----------------------------------------------------------------------------
// Cartridge ROM transfer port register core
// Register file, transfer start decode and word countdown; one item per
// transfer, result formed combinationally from state and item.
// ----------------------------------------------------------------------------
`default_nettype none

module crtp_core
  import crtp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      item_en,
  input  wire in_item_t  item,
  output out_item_t      result
);

  logic [7:0]  cmd_r [COMMAND_LENGTH];
  logic [31:0] ctrl_r, ctrl_nxt;
  logic [31:0] dout_r, dout_nxt;
  logic [31:0] aux_r, aux_nxt;
  logic [14:0] remain_r, remain_nxt;
  logic [1:0]  cur_cmd_r, cur_cmd_nxt;
  logic [11:0] hdr_pos_r, hdr_pos_nxt;
  logic [3:0]  countdown_r, countdown_nxt;
  logic        err_r, err_nxt;

  logic [2:0]  bsize;
  logic [14:0] start_count;
  logic [14:0] remain_dec;
  logic [31:0] rdata;
  logic        irq;

  assign bsize = item.write_data[26:24];

  always_comb begin
    unique case (bsize)
      3'd0:    start_count = '0;
      3'd7:    start_count = BLOCK_SHORT;
      default: start_count = BLOCK_BASE << bsize;
    endcase
  end

  assign remain_dec = (remain_r > WORD_BYTES) ? (remain_r - WORD_BYTES) : '0;

  always_comb begin
    ctrl_nxt      = ctrl_r;
    dout_nxt      = dout_r;
    aux_nxt       = aux_r;
    remain_nxt    = remain_r;
    cur_cmd_nxt   = cur_cmd_r;
    hdr_pos_nxt   = hdr_pos_r;
    countdown_nxt = countdown_r;
    err_nxt       = err_r;
    rdata         = '0;
    irq           = 1'b0;

    unique case (item.operation)
      OP_WRITE: begin
        unique case (item.reg_select)
          REG_CTRL: begin
            ctrl_nxt = item.write_data;
            if (!ctrl_r[BUSY_BIT] && item.write_data[BUSY_BIT]) begin
              ctrl_nxt[READY_BIT] = 1'b0;
              remain_nxt          = start_count;
              unique case (cmd_r[0])
                OPC_DUMMY:   cur_cmd_nxt = CMD_DUMMY;
                OPC_HEADER: begin
                  cur_cmd_nxt = CMD_HEADER;
                  hdr_pos_nxt = '0;
                end
                OPC_CHIP_ID: cur_cmd_nxt = CMD_CHIP_ID;
                OPC_KEY1:    cur_cmd_nxt = CMD_KEY1;
                default: begin
                  err_nxt            = 1'b1;
                  ctrl_nxt[BUSY_BIT] = 1'b0;
                  remain_nxt         = '0;
                end
              endcase
            end
          end
          REG_AUX: aux_nxt = item.write_data;
          default: ;
        endcase
      end
      OP_READ: begin
        unique case (item.reg_select)
          REG_CTRL: rdata = ctrl_r;
          REG_DATA: begin
            if (item.word_read) begin
              rdata = dout_r;
              if (ctrl_r[READY_BIT]) begin
                ctrl_nxt[READY_BIT] = 1'b0;
                countdown_nxt       = CYCLES_PER_WORD;
              end
            end else if (!item.byte_index[2]) begin
              unique case (item.byte_index[1:0])
                2'd0:    rdata = {24'd0, dout_r[7:0]};
                2'd1:    rdata = {24'd0, dout_r[15:8]};
                2'd2:    rdata = {24'd0, dout_r[23:16]};
                default: rdata = {24'd0, dout_r[31:24]};
              endcase
            end
          end
          REG_AUX: rdata = aux_r;
          default: ;
        endcase
      end
      OP_TICK: begin
        if (ctrl_r[BUSY_BIT] && !ctrl_r[READY_BIT]) begin
          if (item.tick_cycles < {4'd0, countdown_r}) begin
            countdown_nxt = countdown_r - item.tick_cycles[3:0];
          end else begin
            countdown_nxt = CYCLES_PER_WORD;
            unique case (cur_cmd_r)
              CMD_DUMMY: dout_nxt = DUMMY_WORD;
              CMD_HEADER: begin
                dout_nxt            = DUMMY_WORD;
                hdr_pos_nxt         = hdr_pos_r + HEADER_STEP;
                ctrl_nxt[READY_BIT] = 1'b1;
              end
              CMD_CHIP_ID: begin
                dout_nxt            = CHIP_ID_WORD;
                ctrl_nxt[READY_BIT] = 1'b1;
              end
              default: ;
            endcase
            remain_nxt = remain_dec;
            if (remain_dec == '0) begin
              ctrl_nxt[BUSY_BIT] = 1'b0;
              irq                = aux_r[IRQ_EN_BIT];
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result.read_data   = rdata;
    result.irq_pulse   = irq;
    result.bad_command = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COMMAND_LENGTH; i++) begin
        cmd_r[i] <= '0;
      end
      ctrl_r      <= '0;
      dout_r      <= '0;
      aux_r       <= '0;
      remain_r    <= '0;
      cur_cmd_r   <= CMD_DUMMY;
      hdr_pos_r   <= '0;
      countdown_r <= CYCLES_PER_WORD;
      err_r       <= 1'b0;
    end else if (item_en) begin
      if (item.operation == OP_WRITE && item.reg_select == REG_CMD) begin
        cmd_r[item.byte_index[CMD_IDX_W-1:0]] <= item.write_data[7:0];
      end
      ctrl_r      <= ctrl_nxt;
      dout_r      <= dout_nxt;
      aux_r       <= aux_nxt;
      remain_r    <= remain_nxt;
      cur_cmd_r   <= cur_cmd_nxt;
      hdr_pos_r   <= hdr_pos_nxt;
      countdown_r <= countdown_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cartridge_rom_transfer_port.sv =====
// An accepted item's result is registered onto out_chan in the next cycle.
// Throughput: one item per cycle unless out_chan stalls; the result register
// frees as taken, so a new item enters in the same cycle a held one leaves.
// Reset: synchronous active-low; clears core registers, command buffer and
// error flag, loads the word countdown with its full count, empties output.
// ----------------------------------------------------------------------------
// Cartridge ROM transfer port
// Register-mapped command buffer, transfer control and data-out word with
// tick-driven word production and a result register on the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module cartridge_rom_transfer_port
  import crtp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  crtp_in_if.sink     in_chan,
  crtp_out_if.source  out_chan
);

  in_item_t  item;
  out_item_t result;
  out_item_t res_r;
  logic      out_valid_r;
  logic      accept;

  assign item.operation   = in_chan.operation;
  assign item.reg_select  = in_chan.reg_select;
  assign item.byte_index  = in_chan.byte_index;
  assign item.word_read   = in_chan.word_read;
  assign item.write_data  = in_chan.write_data;
  assign item.tick_cycles = in_chan.tick_cycles;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  crtp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_en (accept),
    .item    (item),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= result;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.read_data   = res_r.read_data;
  assign out_chan.irq_pulse   = res_r.irq_pulse;
  assign out_chan.bad_command = res_r.bad_command;

endmodule

`default_nettype wire
